// ===== rtl/core/rffc_pkg.sv =====
// ============================================================================
// rffc_pkg: shared types and constants for the register field float converter
// Holds the payload structs, mode and command codes and the CSR indexes.
// ============================================================================
`default_nettype none

package rffc_pkg;

   localparam int WordWidth = 32;

   typedef enum logic [1:0] {
      MODE_UINT  = 2'd0,
      MODE_UFIX  = 2'd1,
      MODE_SFIX  = 2'd2,
      MODE_UNUSED = 2'd3
   } mode_type;

   localparam logic CMD_EXTRACT = 1'b0;
   localparam logic CMD_INSERT  = 1'b1;

   localparam logic [2:0] CSR_FIELD_MASK     = 3'd0;
   localparam logic [2:0] CSR_FIELD_SHIFT    = 3'd1;
   localparam logic [2:0] CSR_FORMAT_MODE    = 3'd2;
   localparam logic [2:0] CSR_FRAC_BITS      = 3'd3;
   localparam logic [2:0] CSR_OVERFLOW_CHECK = 3'd4;

   typedef struct packed {
      logic        command;
      logic [31:0] reg_word;
      logic [31:0] float_in;
   } req_type;

   typedef struct packed {
      logic [31:0] float_out;
      logic [31:0] new_reg_word;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/register_field_float_fixed_convert.sv =====
// ============================================================================
// register_field_float_fixed_convert: float <-> register bit field converter
// Each request passes through stages 1 to 4; stage 4 is the output register
// driving rsp_valid and rsp_data. Throughput one transfer per cycle while
// rsp_ready is high, set by the four-stage pipeline. A stall holds every
// occupied stage while empty ones fill; nothing is dropped or repeated.
// Synchronous active-high reset clears valid bits and restores CSR defaults.
// ============================================================================
`default_nettype none

module register_field_float_fixed_convert (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  rffc_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output rffc_pkg::rsp_type     rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [2:0]            csr_index,
   input  wire  [31:0]           csr_data
);
   import rffc_pkg::*;

   // ---------------------------------------------------------------- CSRs
   logic [31:0] mask_ff;
   logic [4:0]  shift_ff;
   logic [1:0]  mode_ff;
   logic [4:0]  frac_ff;
   logic        ovf_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '1;
         shift_ff <= '0;
         mode_ff  <= MODE_UINT;
         frac_ff  <= '0;
         ovf_ff   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FIELD_MASK:     mask_ff  <= csr_data;
            CSR_FIELD_SHIFT:    shift_ff <= csr_data[4:0];
            CSR_FORMAT_MODE:    mode_ff  <= csr_data[1:0];
            CSR_FRAC_BITS:      frac_ff  <= csr_data[4:0];
            CSR_OVERFLOW_CHECK: ovf_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Derived values; the user keeps CSRs static while items flow, unchecked.
   logic [31:0] fmax;
   logic [5:0]  top_p1;
   logic [5:0]  width;
   logic [4:0]  scale;

   always_comb begin
      top_p1 = '0;
      for (int i = 0; i < 32; i++) begin
         if (mask_ff[i]) top_p1 = 6'(i + 1);
      end
      width = (top_p1 > {1'b0, shift_ff}) ? (top_p1 - {1'b0, shift_ff}) : 6'd0;
      fmax  = mask_ff >> shift_ff;
      scale = (mode_ff == MODE_UINT) ? 5'd0 : frac_ff;
   end

   // Pipeline advance: a stage moves when the stage after it is free or moving.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;
   assign adv4 = !v4_ff || rsp_ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // -------------------------------------------------------------- stage 1
   // Extract: pull the field and take its magnitude/sign.
   // Insert: decode the float into a 24-bit mantissa and a signed shift.
   logic        s1_cmd_ff;
   logic [31:0] s1_word_ff;
   logic        s1_neg_ff;
   logic [31:0] s1_mag_ff;      // extract magnitude
   logic [23:0] s1_man_ff;      // insert mantissa
   logic signed [9:0] s1_sh_ff; // insert shift, left if positive
   logic        s1_sat_ff;      // insert magnitude forced to all ones
   logic        s1_zero_ff;     // insert magnitude forced to zero

   logic        s1_neg_in;
   logic [31:0] s1_mag_in;
   logic [23:0] s1_man_in;
   logic signed [9:0] s1_sh_in;
   logic        s1_sat_in, s1_zero_in;
   logic [31:0] fv;
   logic [7:0]  ex;

   always_comb begin
      fv = (req_data.reg_word & mask_ff) >> shift_ff;
      ex = req_data.float_in[30:23];
      s1_neg_in = 1'b0;
      s1_mag_in = fv;
      if (req_data.command == CMD_EXTRACT) begin
         if (mode_ff == MODE_SFIX && width != 6'd0 && fv[5'(width - 6'd1)]) begin
            s1_neg_in = 1'b1;
            s1_mag_in = (~fv + 32'd1) & fmax;
         end
      end else begin
         s1_neg_in = req_data.float_in[31];
      end
      s1_man_in  = (ex == 8'd0) ? {1'b0, req_data.float_in[22:0]}
                                : {1'b1, req_data.float_in[22:0]};
      s1_sh_in   = ((ex == 8'd0) ? 10'sd1 : $signed({2'b00, ex}))
                   - 10'sd150 + $signed({5'b0, scale});
      s1_sat_in  = 1'b0;
      s1_zero_in = 1'b0;
      if (ex == 8'hFF) begin
         if (req_data.float_in[22:0] != '0) s1_zero_in = 1'b1;
         else                               s1_sat_in  = 1'b1;
      end else if (s1_man_in == '0) begin
         s1_zero_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_cmd_ff  <= req_data.command;
         s1_word_ff <= req_data.reg_word;
         s1_neg_ff  <= s1_neg_in;
         s1_mag_ff  <= s1_mag_in;
         s1_man_ff  <= s1_man_in;
         s1_sh_ff   <= s1_sh_in;
         s1_sat_ff  <= s1_sat_in;
         s1_zero_ff <= s1_zero_in;
      end
   end

   // -------------------------------------------------------------- stage 2
   // Extract: locate the leading one. Insert: scale and round half away.
   logic        s2_cmd_ff;
   logic [31:0] s2_word_ff;
   logic        s2_neg_ff;
   logic [31:0] s2_mag_ff;  // extract magnitude, or insert scaled magnitude
   logic [4:0]  s2_p_ff;

   logic [31:0] s2_mag_in;
   logic [4:0]  s2_p_in;
   logic [33:0] wide;
   logic [4:0]  rsh;

   always_comb begin
      s2_p_in = '0;
      for (int i = 0; i < 32; i++) begin
         if (s1_mag_ff[i]) s2_p_in = 5'(i);
      end
      s2_mag_in = s1_mag_ff;
      wide = '0;
      rsh  = '0;
      if (s1_cmd_ff == CMD_INSERT) begin
         if (s1_zero_ff) begin
            s2_mag_in = '0;
         end else if (s1_sat_ff || s1_sh_ff >= 10'sd9) begin
            s2_mag_in = '1;
         end else if (s1_sh_ff >= 10'sd0) begin
            wide = {10'b0, s1_man_ff} << s1_sh_ff[3:0];
            s2_mag_in = (wide[33:32] != 2'b0) ? '1 : wide[31:0];
         end else if (s1_sh_ff <= -10'sd26) begin
            s2_mag_in = '0;
         end else begin
            rsh  = 5'(-s1_sh_ff);
            wide = ({10'b0, s1_man_ff} + (34'd1 << (rsh - 5'd1))) >> rsh;
            s2_mag_in = wide[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_cmd_ff  <= s1_cmd_ff;
         s2_word_ff <= s1_word_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_mag_ff  <= s2_mag_in;
         s2_p_ff    <= s2_p_in;
      end
   end

   // -------------------------------------------------------------- stage 3
   // Extract: normalize and round to nearest even. Insert: clamp, negate.
   logic        s3_cmd_ff;
   logic [31:0] s3_word_ff;
   logic        s3_neg_ff;
   logic        s3_nz_ff;
   logic [24:0] s3_m_ff;
   logic [8:0]  s3_e_ff;
   logic [31:0] s3_code_ff;
   logic        s3_keep_ff;

   logic [24:0] s3_m_in;
   logic [31:0] s3_code_in;
   logic [31:0] lim, mag;
   logic [31:0] norm;
   logic [4:0]  r;
   logic        rbit, sticky;

   always_comb begin
      // Shift the leading one to bit 31; rounding bits sit below bit 8.
      norm   = s2_mag_ff << (5'd31 - s2_p_ff);
      r      = (s2_p_ff > 5'd23) ? (s2_p_ff - 5'd23) : 5'd0;
      rbit   = norm[7];
      sticky = norm[6:0] != '0;
      s3_m_in = {1'b0, norm[31:8]};
      if (r != 5'd0 && rbit && (sticky || norm[8])) s3_m_in = s3_m_in + 25'd1;

      mag = s2_mag_ff;
      lim = (width == 6'd0) ? 32'd0 : (32'd1 << 5'(width - 6'd1));
      if (mode_ff != MODE_SFIX) begin
         s3_code_in = s2_neg_ff ? 32'd0 : ((mag > fmax) ? fmax : mag);
      end else begin
         if (ovf_ff) begin
            if (width == 6'd0)   mag = '0;
            else if (mag >= lim) mag = s2_neg_ff ? lim : lim - 32'd1;
         end
         s3_code_in = s2_neg_ff ? (~mag + 32'd1) : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_cmd_ff  <= s2_cmd_ff;
         s3_word_ff <= s2_word_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_nz_ff   <= s2_mag_ff != '0;
         s3_m_ff    <= s3_m_in;
         s3_e_ff    <= 9'({4'b0, s2_p_ff} + 9'd127 - {4'b0, scale});
         s3_code_ff <= s3_code_in;
         s3_keep_ff <= mode_ff == MODE_UNUSED;
      end
   end

   // -------------------------------------------------------------- stage 4
   // Pack the float or merge the code, then hold in the output register.
   rsp_type     s4_in;
   rsp_type     s4_ff;
   logic [24:0] mf;
   logic [7:0]  ef;

   always_comb begin
      mf = s3_m_ff;
      ef = s3_e_ff[7:0];
      if (mf[24]) begin
         mf = mf >> 1;
         ef = ef + 8'd1;
      end
      s4_in.new_reg_word = s3_word_ff;
      s4_in.float_out    = '0;
      if (s3_cmd_ff == CMD_EXTRACT) begin
         if (!s3_keep_ff) begin
            s4_in.float_out = s3_nz_ff ? {s3_neg_ff, ef, mf[22:0]}
                                       : {s3_neg_ff, 31'b0};
         end
      end else if (!s3_keep_ff) begin
         s4_in.new_reg_word = ((s3_code_ff << shift_ff) & mask_ff)
                              | (s3_word_ff & ~mask_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) s4_ff <= s4_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = s4_ff;

endmodule

`default_nettype wire

// ===== test/rffc_checker.sv =====
// ============================================================================
// rffc_checker: response predictor and scoreboard for the field converter
// Watches the CSR, request and response channels, computes the expected
// float/word pair for every request transfer and compares in order.
// ============================================================================
`default_nettype none

module rffc_checker (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   input  wire                req_ready,
   input  rffc_pkg::req_type  req_data,
   input  wire                rsp_valid,
   input  wire                rsp_ready,
   input  rffc_pkg::rsp_type  rsp_data,
   input  wire                csr_valid,
   input  wire                csr_ready,
   input  wire  [2:0]         csr_index,
   input  wire  [31:0]        csr_data,
   output int                 error_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rffc_pkg::*;

   logic [31:0] mask_q;
   logic [4:0]  shift_q;
   mode_type    mode_q;
   logic [4:0]  frac_q;
   logic        ovf_q;
   rsp_type     conversion_queue[$];

   assign pending_count = conversion_queue.size();

   function automatic logic [31:0] pack_float(logic neg, logic [31:0] mag, logic [4:0] scale);
      int          top;
      logic [31:0] man, ex, rem, half;
      int          r;
      if (mag == 0) return {neg, 31'd0};
      top = 31;
      while (mag[top] == 1'b0) top--;
      ex = top + 127 - scale;
      if (top <= 23) man = mag << (23 - top);
      else begin
         r = top - 23;
         rem = mag & ((32'd1 << r) - 1);
         half = 32'd1 << (r - 1);
         man = mag >> r;
         if (rem > half || (rem == half && man[0])) man++;
         if (man >= 32'h100_0000) begin
            man >>= 1;
            ex++;
         end
      end
      return {neg, ex[7:0], man[22:0]};
   endfunction

   function automatic logic [31:0] scale_round(logic [31:0] bits, logic [4:0] scale);
      logic [7:0]  ex;
      logic [23:0] man;
      int          e, s;
      logic [63:0] wide;
      ex = bits[30:23];
      if (ex == 8'hFF) return (bits[22:0] != 0) ? 32'd0 : 32'hFFFF_FFFF;
      if (ex == 0) begin
         man = {1'b0, bits[22:0]};
         e = 1;
      end else begin
         man = {1'b1, bits[22:0]};
         e = ex;
      end
      if (man == 0) return 32'd0;
      s = e - 150 + scale;
      if (s >= 9) return 32'hFFFF_FFFF;
      if (s >= 0) begin
         wide = 64'(man) << s;
         return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      end
      if (-s >= 26) return 32'd0;
      wide = (64'(man) + (64'd1 << (-s - 1))) >> (-s);
      return wide[31:0];
   endfunction

   function automatic rsp_type convert(req_type rq);
      rsp_type     res;
      logic [31:0] fmax, fv, mag, code, lim;
      int          width, top;
      logic [4:0]  scale;
      logic        neg;
      fmax = mask_q >> shift_q;
      top = 31;
      while (top >= 0 && !mask_q[top]) top--;
      width = (top + 1 - int'(shift_q) > 0) ? top + 1 - int'(shift_q) : 0;
      scale = (mode_q == MODE_UINT) ? 5'd0 : frac_q;
      res.float_out = 32'd0;
      res.new_reg_word = rq.reg_word;
      if (rq.command == CMD_EXTRACT) begin
         fv = (rq.reg_word & mask_q) >> shift_q;
         if (mode_q == MODE_UINT || mode_q == MODE_UFIX)
            res.float_out = pack_float(1'b0, fv, scale);
         else if (mode_q == MODE_SFIX) begin
            if (width > 0 && fv[width-1])
               res.float_out = pack_float(1'b1, (~fv + 1) & fmax, scale);
            else
               res.float_out = pack_float(1'b0, fv, scale);
         end
      end else if (mode_q != MODE_UNUSED) begin
         neg = rq.float_in[31];
         mag = scale_round(rq.float_in, scale);
         if (mode_q != MODE_SFIX) code = neg ? 32'd0 : ((mag > fmax) ? fmax : mag);
         else begin
            if (ovf_q) begin
               if (width == 0) mag = 0;
               else begin
                  lim = 32'd1 << (width - 1);
                  if (mag >= lim) mag = neg ? lim : lim - 1;
               end
            end
            code = neg ? (~mag + 1) : mag;
         end
         res.new_reg_word = ((code << shift_q) & mask_q) | (rq.reg_word & ~mask_q);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = error_count;
      if (reset) begin
         mask_q <= 32'hFFFF_FFFF;
         shift_q <= 0;
         mode_q <= MODE_UINT;
         frac_q <= 0;
         ovf_q <= 1'b1;
         error_count <= 0;
         conversion_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIELD_MASK:     mask_q <= csr_data;
               CSR_FIELD_SHIFT:    shift_q <= csr_data[4:0];
               CSR_FORMAT_MODE:    mode_q <= mode_type'(csr_data[1:0]);
               CSR_FRAC_BITS:      frac_q <= csr_data[4:0];
               CSR_OVERFLOW_CHECK: ovf_q <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            conversion_queue.insert(conversion_queue.size(), convert(req_data));
         if (rsp_valid && rsp_ready) begin
            if (conversion_queue.size() == 0) begin
               $error("unexpected response %h", rsp_data);
               errs++;
            end else begin
               want = conversion_queue.pop_front();
               if (want.float_out !== rsp_data.float_out) begin
                  $error("float_out expected %h actual %h", want.float_out, rsp_data.float_out);
                  errs++;
               end
               if (want.new_reg_word !== rsp_data.new_reg_word) begin
                  $error("new_reg_word expected %h actual %h",
                         want.new_reg_word, rsp_data.new_reg_word);
                  errs++;
               end
            end
         end
         error_count <= errs;
      end
   end

endmodule

`default_nettype wire

// ===== test/tb_register_field_float_fixed_convert.sv =====
// ============================================================================
// tb_register_field_float_fixed_convert: regression for the field converter
// Walks several field layouts and formats, sending directed corner values
// and then random extract/insert traffic with random gaps and backpressure.
// ============================================================================
`default_nettype none

module tb_register_field_float_fixed_convert;
   timeunit 1ns;
   timeprecision 1ps;
   import rffc_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   req_type     req_data;
   logic        rsp_valid, rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;
   int          error_count, pending_count;
   // receiver control: hold-off requests from the sender side, the receiver's
   // own count of them and of the cycles left, and whether random stalls apply
   int          hold_req;
   int          hold_ack;
   int          hold_cycles;
   logic        calm;

   register_field_float_fixed_convert dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   rffc_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .error_count, .pending_count
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: random stalls, a long hold-off when requested, none when calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 0;
         hold_ack <= hold_req;
      end else if (hold_ack != hold_req) begin
         rsp_ready <= 1'b0;
         hold_cycles <= 200;
         hold_ack <= hold_req;
      end else if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
   end

   // Write one CSR and wait for its transfer.
   task automatic write_csr(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Drain everything outstanding, then let the pipeline settle.
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_layout(logic [31:0] mask, logic [4:0] shift, mode_type mode,
                             logic [4:0] frac, logic ovf);
      drain();
      write_csr(CSR_FIELD_MASK, mask);
      write_csr(CSR_FIELD_SHIFT, 32'(shift));
      write_csr(CSR_FORMAT_MODE, 32'(mode));
      write_csr(CSR_FRAC_BITS, 32'(frac));
      write_csr(CSR_OVERFLOW_CHECK, 32'(ovf));
   endtask

   // Send one request; hold valid across back-to-back items, idle only at random.
   task automatic send_item(logic cmd, logic [31:0] word, logic [31:0] fin);
      if (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: cmd, reg_word: word, float_in: fin};
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [31:0] random_float();
      case ($urandom_range(7))
         0: return {1'($urandom_range(1)), 8'hFF, 23'd0};
         1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
         2: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
         3: return {1'($urandom_range(1)), 8'($urandom_range(100, 170)), 23'($urandom)};
         4: return {1'($urandom_range(1)), 8'($urandom_range(120, 135)),
                    23'($urandom_range(3)) << 20};
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] mask;
      logic [4:0]  shift;
      int          top;
      logic [31:0] corners[10];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_req = 0;
      calm = 1'b0;
      corners = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'hBFC0_0000,
                  32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001,
                  32'h4F80_0000, 32'hCF00_0000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset layout, then a narrow signed field with each corner.
      send_item(CMD_EXTRACT, 32'hFFFF_FFFF, 32'h0);
      send_item(CMD_EXTRACT, 32'h0000_0001, 32'h0);
      send_item(CMD_INSERT, 32'h1234_5678, 32'h4F80_0000);
      req_valid <= 1'b0;
      set_layout(32'h0000_0FF0, 5'd4, MODE_SFIX, 5'd2, 1'b1);
      foreach (corners[i]) send_item(CMD_INSERT, 32'hA5A5_A5A5, corners[i]);
      send_item(CMD_EXTRACT, 32'h0000_0800, 32'h0);
      send_item(CMD_EXTRACT, 32'h0000_07F0, 32'h0);
      req_valid <= 1'b0;
      // Empty field, unused mode, and overflow check off.
      set_layout(32'h0000_000F, 5'd8, MODE_SFIX, 5'd31, 1'b0);
      send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'hC2C8_0000);
      send_item(CMD_EXTRACT, 32'hFFFF_FFFF, 32'h0);
      req_valid <= 1'b0;
      set_layout(32'hFFFF_FFFF, 5'd0, MODE_UNUSED, 5'd0, 1'b0);
      send_item(CMD_INSERT, 32'h0, 32'h3F80_0000);
      send_item(CMD_EXTRACT, 32'hDEAD_BEEF, 32'h0);
      req_valid <= 1'b0;

      // Random phases over varied layouts; 12 phases of 100 items each.
      for (int phase = 0; phase < 12; phase++) begin
         top = $urandom_range(31);
         shift = 5'($urandom_range(top));
         mask = (top == 31) ? 32'hFFFF_FFFF : ((32'd1 << (top + 1)) - 1);
         mask = mask & ~((32'd1 << shift) - 1);
         if ($urandom_range(3) == 0) mask = mask | $urandom;
         if (phase == 0) begin
            mask = 32'h1;
            shift = 0;
         end
         set_layout(mask, shift, mode_type'(phase % 4 == 3 ? $urandom_range(3) : phase % 3),
                    5'(phase == 1 ? 31 : $urandom_range(31)), 1'($urandom_range(1)));
         calm = (phase == 5);
         if (phase == 3) hold_req <= hold_req + 1;
         for (int n = 0; n < 100; n++)
            send_item(1'($urandom_range(1)), $urandom, random_float());
         req_valid <= 1'b0;
         if (phase == 7) drain();
      end
      calm = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
